// ----- sv/avm_pkg.sv -----
// Shared types and constants for the accumulator/stack VM core.
// Opcodes, status codes, configuration indexes and the mul/div unit opcode.
// No dependencies.
package avm_pkg;

    localparam logic [5:0] OP_LEA  = 6'd0;
    localparam logic [5:0] OP_LST  = 6'd1;
    localparam logic [5:0] OP_LDA  = 6'd2;
    localparam logic [5:0] OP_LIM  = 6'd3;
    localparam logic [5:0] OP_JMP  = 6'd4;
    localparam logic [5:0] OP_JSR  = 6'd5;
    localparam logic [5:0] OP_BZ   = 6'd6;
    localparam logic [5:0] OP_BNZ  = 6'd7;
    localparam logic [5:0] OP_ENT  = 6'd8;
    localparam logic [5:0] OP_ADJ  = 6'd9;
    localparam logic [5:0] OP_LEV  = 6'd10;
    localparam logic [5:0] OP_LI   = 6'd11;
    localparam logic [5:0] OP_LC   = 6'd12;
    localparam logic [5:0] OP_SI   = 6'd13;
    localparam logic [5:0] OP_SC   = 6'd14;
    localparam logic [5:0] OP_PSH  = 6'd15;
    localparam logic [5:0] OP_OR   = 6'd16;
    localparam logic [5:0] OP_XOR  = 6'd17;
    localparam logic [5:0] OP_AND  = 6'd18;
    localparam logic [5:0] OP_EQ   = 6'd19;
    localparam logic [5:0] OP_NE   = 6'd20;
    localparam logic [5:0] OP_LT   = 6'd21;
    localparam logic [5:0] OP_GT   = 6'd22;
    localparam logic [5:0] OP_LE   = 6'd23;
    localparam logic [5:0] OP_GE   = 6'd24;
    localparam logic [5:0] OP_SHL  = 6'd25;
    localparam logic [5:0] OP_SHR  = 6'd26;
    localparam logic [5:0] OP_ADD  = 6'd27;
    localparam logic [5:0] OP_SUB  = 6'd28;
    localparam logic [5:0] OP_MUL  = 6'd29;
    localparam logic [5:0] OP_DIV  = 6'd30;
    localparam logic [5:0] OP_MOD  = 6'd31;
    localparam logic [5:0] OP_HOST_FIRST = 6'd32;
    localparam logic [5:0] OP_HOST_LAST  = 6'd42;
    localparam logic [5:0] OP_EXIT = 6'd43;

    localparam logic [2:0] ST_RUNNING = 3'd0;
    localparam logic [2:0] ST_EXITED  = 3'd1;
    localparam logic [2:0] ST_BAD_OP  = 3'd2;
    localparam logic [2:0] ST_HOST    = 3'd3;
    localparam logic [2:0] ST_DIV0    = 3'd4;
    localparam logic [2:0] ST_ADDR    = 3'd5;

    localparam logic [2:0] CFG_ENTRY_PC = 3'd0;
    localparam logic [2:0] CFG_ARGC     = 3'd1;
    localparam logic [2:0] CFG_ARGV     = 3'd2;
    localparam logic [2:0] CFG_DATA     = 3'd3;
    localparam logic [2:0] CFG_SYMBOL   = 3'd4;

    typedef logic [1:0] md_op_t;
    localparam md_op_t MD_MUL = 2'd0;
    localparam md_op_t MD_DIV = 2'd1;
    localparam md_op_t MD_REM = 2'd2;

endpackage

// ----- sv/avm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module avm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8192
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/avm_muldiv.sv -----
// Shared iterative multiply/divide unit: 64-bit low product from three
// 32x32 partial products, signed divide/remainder one quotient bit a cycle.
// Depends on avm_pkg.
module avm_muldiv (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  avm_pkg::md_op_t op,
    input  logic [63:0]     x,
    input  logic [63:0]     y,
    output logic            done,
    output logic [63:0]     result
);
    import avm_pkg::*;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    md_op_t      op_reg, op_next;
    logic [63:0] a_reg, a_next;
    logic [63:0] b_reg, b_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] quo_reg, quo_next;
    logic        negq_reg, negq_next;
    logic        negr_reg, negr_next;

    logic [31:0] mul_l, mul_r;
    logic [63:0] prod;
    logic [64:0] r_sh, diff;

    always_comb begin
        unique case (cnt_reg[1:0])
            2'd0:    begin mul_l = a_reg[31:0];  mul_r = b_reg[31:0];  end
            2'd1:    begin mul_l = a_reg[31:0];  mul_r = b_reg[63:32]; end
            default: begin mul_l = a_reg[63:32]; mul_r = b_reg[31:0];  end
        endcase
        prod = 64'(mul_l) * 64'(mul_r);
        r_sh = {acc_reg, quo_reg[63]};
        diff = r_sh - {1'b0, b_reg};
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        op_next   = op_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        quo_next  = quo_reg;
        negq_next = negq_reg;
        negr_next = negr_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            op_next   = op;
            acc_next  = '0;
            a_next    = x;
            b_next    = y;
            if (op != MD_MUL) begin
                negq_next = x[63] ^ y[63];
                negr_next = x[63];
                quo_next  = x[63] ? (64'd0 - x) : x;
                b_next    = y[63] ? (64'd0 - y) : y;
            end
        end else if (busy_reg) begin
            cnt_next = cnt_reg + 6'd1;
            if (op_reg == MD_MUL) begin
                acc_next = acc_reg + ((cnt_reg == 6'd0) ? prod : {prod[31:0], 32'd0});
                if (cnt_reg == 6'd2) begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end else begin
                acc_next = diff[64] ? r_sh[63:0] : diff[63:0];
                quo_next = {quo_reg[62:0], ~diff[64]};
                if (cnt_reg == 6'd63) begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg  <= cnt_next;
        op_reg   <= op_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        acc_reg  <= acc_next;
        quo_reg  <= quo_next;
        negq_reg <= negq_next;
        negr_reg <= negr_next;
    end

    always_comb begin
        unique case (op_reg)
            MD_MUL:  result = acc_reg;
            MD_DIV:  result = negq_reg ? (64'd0 - quo_reg) : quo_reg;
            default: result = negr_reg ? (64'd0 - acc_reg) : acc_reg;
        endcase
    end

    assign done = done_reg;

endmodule

// ----- sv/accumulator_stack_vm_core_unit.sv -----
// Accumulator/stack VM core: one instruction or one memory preload per input word.
// Depends on avm_pkg, avm_ram (data/stack memory) and avm_muldiv (shared mul/div).
//
// Each input word runs through a small sequencer over one data memory port.
// A preload, a step while halted, and instructions without a memory read go
// from S_EXEC straight to S_DONE; LI, LC, SI, EXIT and the ALU/compare/shift ops
// also pass S_X1; LEV and SC pass S_X1 and S_X2; MUL/DIV/MOD wait in S_MD for
// the shared multiply/divide unit. After reset the block writes the initial
// stack frame, and after an entry_pc write it subtracts CODE_WORDS from the
// program counter until it fits, before it accepts input words.
module accumulator_stack_vm_core_unit #(
    parameter int CODE_WORDS  = 16384,
    parameter int MEM_BYTES   = 65536,
    parameter int STACK_BYTES = 10240
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // opcode[5:0], operand[37:6], load_address[50:38], load_data[114:51]
    input  logic [119:0] s_tdata,
    // func[0]
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // next_pc[13:0], acc_value[77:14], status[80:78], exit_value[144:81]
    output logic [151:0] m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [15:0]  cfg_data
);
    import avm_pkg::*;

    localparam int MEM_WORDS = MEM_BYTES / 8;
    localparam int WA  = $clog2(MEM_WORDS);
    localparam int PW  = $clog2(MEM_WORDS * 8 + 1);
    localparam int PCW = ($clog2(CODE_WORDS) + 1 > 14) ? $clog2(CODE_WORDS) + 1 : 14;
    localparam logic [63:0] MEM_TOP   = 64'(MEM_WORDS) * 64'd8;
    localparam logic [63:0] TOP_M8    = MEM_TOP - 64'd8;
    localparam logic [63:0] TOP_M16   = MEM_TOP - 64'd16;
    localparam logic [63:0] STACK_LOW = (MEM_TOP > 64'(STACK_BYTES)) ?
                                        MEM_TOP - 64'(STACK_BYTES) : 64'd0;
    localparam logic [63:0] CODE_LIM  = 64'(CODE_WORDS);
    localparam logic [63:0] LAST_WORD = 64'(MEM_WORDS - 1);

    localparam logic [2:0] S_INIT = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_EXEC = 3'd2;
    localparam logic [2:0] S_X1   = 3'd3;
    localparam logic [2:0] S_X2   = 3'd4;
    localparam logic [2:0] S_MD   = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0]     state_reg, state_next;
    logic [2:0]     init_cnt_reg, init_cnt_next;
    logic [PCW-1:0] pc_reg, pc_next;
    logic [63:0]    acc_reg, acc_next;
    logic [PW-1:0]  sp_reg, sp_next;
    logic [PW-1:0]  bp_reg, bp_next;
    logic           halted_reg, halted_next;
    logic [2:0]     hstat_reg, hstat_next;
    logic [63:0]    xval_reg, xval_next;
    logic [7:0]     argc_reg, argc_next;
    logic [15:0]    argv_reg, argv_next;
    logic [15:0]    dbase_reg, dbase_next;
    logic [15:0]    sbase_reg, sbase_next;
    logic           func_reg, func_next;
    logic [5:0]     op_reg, op_next;
    logic [31:0]    opd_reg, opd_next;
    logic [12:0]    ldaddr_reg, ldaddr_next;
    logic [63:0]    lddata_reg, lddata_next;
    logic [63:0]    tmp_reg, tmp_next;
    logic           m_tvalid_reg, m_tvalid_next;
    logic [151:0]   m_tdata_reg, m_tdata_next;

    logic           ram_we;
    logic [WA-1:0]  ram_waddr, ram_raddr;
    logic [63:0]    ram_wdata, ram_rdata;

    logic           md_start, md_done;
    md_op_t         md_op;
    logic [63:0]    md_result;

    logic [63:0] sp64, bp64, opd64, opd8, spm8, spp8, bpp8, bpp16, nsp_ent, nsp_adj;
    logic [63:0] a, x, alu, nb, np, w_tmp, ld_idx, sc_word, init_word, pc64;
    logic [63:0] jt_wide, seq_wide;
    logic [PCW:0] seq_sum;
    logic [PCW-1:0] seq, jt;
    logic        jump_ok, push_ok, sp_word_ok, cfg_fire, cfg_mem, pc_fit, take;
    logic [2:0]  out_stat;

    avm_ram #(.WIDTH(64), .DEPTH(MEM_WORDS)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    avm_muldiv u_muldiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (md_start),
        .op      (md_op),
        .x       (ram_rdata),
        .y       (acc_reg),
        .done    (md_done),
        .result  (md_result)
    );

    always_comb begin
        a       = acc_reg;
        x       = ram_rdata;
        sp64    = 64'(sp_reg);
        bp64    = 64'(bp_reg);
        opd64   = {{32{opd_reg[31]}}, opd_reg};
        opd8    = opd64 << 3;
        spm8    = sp64 - 64'd8;
        spp8    = sp64 + 64'd8;
        bpp8    = bp64 + 64'd8;
        bpp16   = bp64 + 64'd16;
        nsp_ent = spm8 - opd8;
        nsp_adj = sp64 + opd8;
        push_ok = $signed(spm8) >= $signed(STACK_LOW);
        sp_word_ok = (sp64 <= TOP_M8) && (sp64[2:0] == 3'd0);
        jump_ok = !opd_reg[31] && (opd_reg[2:0] == 3'd0) && (64'(opd_reg[30:3]) < CODE_LIM);
        jt_wide = 64'(opd_reg[30:3]);
        jt      = jt_wide[PCW-1:0];
        seq_sum = {1'b0, pc_reg} + (PCW + 1)'((op_reg <= OP_ADJ) ? 2 : 1);
        seq_wide = (64'(seq_sum) >= CODE_LIM) ? 64'(seq_sum) - CODE_LIM : 64'(seq_sum);
        seq     = seq_wide[PCW-1:0];
        take    = (op_reg == OP_BZ) == (a == 64'd0);
        pc_fit  = 64'(pc_reg) < CODE_LIM;
        pc64    = 64'(pc_reg);
        ld_idx  = 64'(ldaddr_reg);
        nb      = tmp_reg;
        np      = ram_rdata;
        sc_word = ram_rdata;
        sc_word[{tmp_reg[2:0], 3'b000} +: 8] = a[7:0];
        unique case (op_reg)
            OP_OR:   alu = x | a;
            OP_XOR:  alu = x ^ a;
            OP_AND:  alu = x & a;
            OP_EQ:   alu = 64'(x == a);
            OP_NE:   alu = 64'(x != a);
            OP_LT:   alu = 64'($signed(x) < $signed(a));
            OP_GT:   alu = 64'($signed(x) > $signed(a));
            OP_LE:   alu = 64'($signed(x) <= $signed(a));
            OP_GE:   alu = 64'($signed(x) >= $signed(a));
            OP_SHL:  alu = (a >= 64'd64) ? 64'd0 : (x << a[5:0]);
            OP_SHR:  alu = (a >= 64'd64) ? {64{x[63]}} : 64'($signed(x) >>> a[5:0]);
            OP_ADD:  alu = x + a;
            OP_SUB:  alu = x - a;
            default: alu = x;
        endcase
        unique case (init_cnt_reg)
            3'd0:    init_word = 64'(OP_EXIT);
            3'd1:    init_word = 64'(OP_PSH);
            3'd2:    init_word = 64'(argc_reg);
            3'd3:    init_word = 64'(argv_reg);
            default: init_word = {64{1'b1}};
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        init_cnt_next = init_cnt_reg;
        pc_next       = pc_reg;
        acc_next      = acc_reg;
        sp_next       = sp_reg;
        bp_next       = bp_reg;
        halted_next   = halted_reg;
        hstat_next    = hstat_reg;
        xval_next     = xval_reg;
        argc_next     = argc_reg;
        argv_next     = argv_reg;
        dbase_next    = dbase_reg;
        sbase_next    = sbase_reg;
        func_next     = func_reg;
        op_next       = op_reg;
        opd_next      = opd_reg;
        ldaddr_next   = ldaddr_reg;
        lddata_next   = lddata_reg;
        tmp_next      = tmp_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        ram_we        = 1'b0;
        ram_waddr     = '0;
        ram_wdata     = '0;
        ram_raddr     = '0;
        md_start      = 1'b0;
        md_op         = MD_MUL;
        w_tmp         = '0;
        out_stat      = halted_reg ? hstat_reg : ST_RUNNING;

        cfg_ready = (state_reg == S_IDLE) || (state_reg == S_INIT);
        s_tready  = (state_reg == S_IDLE) && pc_fit;
        cfg_fire  = cfg_valid && cfg_ready;
        cfg_mem   = cfg_fire && ((cfg_index == CFG_ARGC) || (cfg_index == CFG_ARGV));

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        if (cfg_ready && !pc_fit) begin
            pc_next = pc_reg - PCW'(CODE_WORDS);
        end

        if (cfg_fire) begin
            unique case (cfg_index)
                CFG_ENTRY_PC: pc_next = PCW'(cfg_data[13:0]);
                CFG_ARGC: begin
                    argc_next = cfg_data[7:0];
                    ram_we    = 1'b1;
                    w_tmp     = LAST_WORD - 64'd2;
                    ram_waddr = w_tmp[WA-1:0];
                    ram_wdata = 64'(cfg_data[7:0]);
                end
                CFG_ARGV: begin
                    argv_next = cfg_data;
                    ram_we    = 1'b1;
                    w_tmp     = LAST_WORD - 64'd3;
                    ram_waddr = w_tmp[WA-1:0];
                    ram_wdata = 64'(cfg_data);
                end
                CFG_DATA:   dbase_next = cfg_data;
                CFG_SYMBOL: sbase_next = cfg_data;
                default: ;
            endcase
        end

        unique case (state_reg)
            S_INIT: begin
                if (!cfg_mem) begin
                    ram_we        = 1'b1;
                    w_tmp         = LAST_WORD - 64'(init_cnt_reg);
                    ram_waddr     = w_tmp[WA-1:0];
                    ram_wdata     = init_word;
                    init_cnt_next = init_cnt_reg + 3'd1;
                    if (init_cnt_reg == 3'd4) begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    func_next   = s_tuser;
                    op_next     = s_tdata[5:0];
                    opd_next    = s_tdata[37:6];
                    ldaddr_next = s_tdata[50:38];
                    lddata_next = s_tdata[114:51];
                    state_next  = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = S_DONE;
                if (func_reg) begin
                    if (ld_idx < 64'(MEM_WORDS)) begin
                        ram_we    = 1'b1;
                        ram_waddr = ld_idx[WA-1:0];
                        ram_wdata = lddata_reg;
                    end
                end else if (!halted_reg) begin
                    unique case (op_reg)
                        OP_LEA: begin acc_next = bp64 + opd8; pc_next = seq; end
                        OP_LST: begin acc_next = 64'(sbase_reg) + opd8; pc_next = seq; end
                        OP_LDA: begin acc_next = 64'(dbase_reg) + opd64; pc_next = seq; end
                        OP_LIM: begin acc_next = opd64; pc_next = seq; end
                        OP_JMP: begin
                            if (jump_ok) pc_next = jt;
                            else begin halted_next = 1'b1; hstat_next = ST_ADDR; xval_next = '0; end
                        end
                        OP_JSR: begin
                            if (!jump_ok || !push_ok) begin
                                halted_next = 1'b1; hstat_next = ST_ADDR; xval_next = '0;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = spm8[WA+2:3];
                                ram_wdata = 64'(seq);
                                sp_next   = spm8[PW-1:0];
                                pc_next   = jt;
                            end
                        end
                        OP_BZ, OP_BNZ: begin
                            if (!take) pc_next = seq;
                            else if (jump_ok) pc_next = jt;
                            else begin halted_next = 1'b1; hstat_next = ST_ADDR; xval_next = '0; end
                        end
                        OP_ENT: begin
                            if (!push_ok || $signed(nsp_ent) < $signed(STACK_LOW) ||
                                $signed(nsp_ent) > $signed(MEM_TOP)) begin
                                halted_next = 1'b1; hstat_next = ST_ADDR; xval_next = '0;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = spm8[WA+2:3];
                                ram_wdata = bp64;
                                bp_next   = spm8[PW-1:0];
                                sp_next   = nsp_ent[PW-1:0];
                                pc_next   = seq;
                            end
                        end
                        OP_ADJ: begin
                            if ($signed(nsp_adj) < $signed(STACK_LOW) ||
                                $signed(nsp_adj) > $signed(MEM_TOP)) begin
                                halted_next = 1'b1; hstat_next = ST_ADDR; xval_next = '0;
                            end else begin
                                sp_next = nsp_adj[PW-1:0];
                                pc_next = seq;
                            end
                        end
                        OP_LEV: begin
                            if (bp64 < STACK_LOW || bp64 > TOP_M16 || bp64[2:0] != 3'd0) begin
                                halted_next = 1'b1; hstat_next = ST_ADDR; xval_next = '0;
                            end else begin
                                ram_raddr  = bp64[WA+2:3];
                                state_next = S_X1;
                            end
                        end
                        OP_LI: begin
                            if (a > TOP_M8 || a[2:0] != 3'd0) begin
                                halted_next = 1'b1; hstat_next = ST_ADDR; xval_next = '0;
                            end else begin
                                ram_raddr  = a[WA+2:3];
                                state_next = S_X1;
                            end
                        end
                        OP_LC: begin
                            if (a >= MEM_TOP) begin
                                halted_next = 1'b1; hstat_next = ST_ADDR; xval_next = '0;
                            end else begin
                                ram_raddr  = a[WA+2:3];
                                state_next = S_X1;
                            end
                        end
                        OP_PSH: begin
                            if (!push_ok) begin
                                halted_next = 1'b1; hstat_next = ST_ADDR; xval_next = '0;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = spm8[WA+2:3];
                                ram_wdata = a;
                                sp_next   = spm8[PW-1:0];
                                pc_next   = seq;
                            end
                        end
                        OP_SI, OP_SC, OP_OR, OP_XOR, OP_AND, OP_EQ, OP_NE, OP_LT, OP_GT,
                        OP_LE, OP_GE, OP_SHL, OP_SHR, OP_ADD, OP_SUB, OP_MUL, OP_DIV,
                        OP_MOD, OP_EXIT: begin
                            if (!sp_word_ok) begin
                                halted_next = 1'b1; hstat_next = ST_ADDR; xval_next = '0;
                            end else begin
                                ram_raddr  = sp64[WA+2:3];
                                state_next = S_X1;
                            end
                        end
                        default: begin
                            halted_next = 1'b1;
                            xval_next   = '0;
                            hstat_next  = (op_reg >= OP_HOST_FIRST && op_reg <= OP_HOST_LAST) ?
                                          ST_HOST : ST_BAD_OP;
                        end
                    endcase
                end
            end
            S_X1: begin
                state_next = S_DONE;
                unique case (op_reg)
                    OP_LEV: begin
                        tmp_next   = ram_rdata;
                        ram_raddr  = bpp8[WA+2:3];
                        state_next = S_X2;
                    end
                    OP_LI: begin acc_next = ram_rdata; pc_next = seq; end
                    OP_LC: begin
                        w_tmp    = 64'(ram_rdata[{a[2:0], 3'b000} +: 8]);
                        acc_next = {{56{w_tmp[7]}}, w_tmp[7:0]};
                        pc_next  = seq;
                    end
                    OP_SI: begin
                        if (x > TOP_M8 || x[2:0] != 3'd0) begin
                            halted_next = 1'b1; hstat_next = ST_ADDR; xval_next = '0;
                        end else begin
                            ram_we    = 1'b1;
                            ram_waddr = x[WA+2:3];
                            ram_wdata = a;
                            sp_next   = spp8[PW-1:0];
                            pc_next   = seq;
                        end
                    end
                    OP_SC: begin
                        if (x >= MEM_TOP) begin
                            halted_next = 1'b1; hstat_next = ST_ADDR; xval_next = '0;
                        end else begin
                            tmp_next   = x;
                            ram_raddr  = x[WA+2:3];
                            state_next = S_X2;
                        end
                    end
                    OP_EXIT: begin
                        halted_next = 1'b1; hstat_next = ST_EXITED; xval_next = x;
                    end
                    OP_MUL, OP_DIV, OP_MOD: begin
                        if (op_reg != OP_MUL && a == 64'd0) begin
                            halted_next = 1'b1; hstat_next = ST_DIV0; xval_next = '0;
                        end else begin
                            md_start   = 1'b1;
                            md_op      = (op_reg == OP_MUL) ? MD_MUL :
                                         (op_reg == OP_DIV) ? MD_DIV : MD_REM;
                            state_next = S_MD;
                        end
                    end
                    default: begin
                        acc_next = alu;
                        sp_next  = spp8[PW-1:0];
                        pc_next  = seq;
                    end
                endcase
            end
            S_X2: begin
                state_next = S_DONE;
                if (op_reg == OP_LEV) begin
                    if (nb > MEM_TOP || nb[2:0] != 3'd0) begin
                        halted_next = 1'b1; hstat_next = ST_ADDR; xval_next = '0;
                    end else if (np == {64{1'b1}}) begin
                        sp_next     = bpp16[PW-1:0];
                        bp_next     = nb[PW-1:0];
                        halted_next = 1'b1; hstat_next = ST_EXITED; xval_next = a;
                    end else if (np >= CODE_LIM) begin
                        halted_next = 1'b1; hstat_next = ST_ADDR; xval_next = '0;
                    end else begin
                        sp_next = bpp16[PW-1:0];
                        bp_next = nb[PW-1:0];
                        pc_next = np[PCW-1:0];
                    end
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = tmp_reg[WA+2:3];
                    ram_wdata = sc_word;
                    acc_next  = {{56{a[7]}}, a[7:0]};
                    sp_next   = spp8[PW-1:0];
                    pc_next   = seq;
                end
            end
            S_MD: begin
                if (md_done) begin
                    acc_next   = md_result;
                    sp_next    = spp8[PW-1:0];
                    pc_next    = seq;
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {7'd0,
                                     (halted_reg && hstat_reg == ST_EXITED) ? xval_reg : 64'd0,
                                     out_stat, acc_reg, pc64[13:0]};
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_INIT;
            init_cnt_reg <= '0;
            pc_reg       <= '0;
            acc_reg      <= '0;
            sp_reg       <= PW'(MEM_TOP - 64'd40);
            bp_reg       <= PW'(MEM_TOP);
            halted_reg   <= 1'b0;
            hstat_reg    <= ST_RUNNING;
            xval_reg     <= '0;
            argc_reg     <= '0;
            argv_reg     <= '0;
            dbase_reg    <= '0;
            sbase_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            init_cnt_reg <= init_cnt_next;
            pc_reg       <= pc_next;
            acc_reg      <= acc_next;
            sp_reg       <= sp_next;
            bp_reg       <= bp_next;
            halted_reg   <= halted_next;
            hstat_reg    <= hstat_next;
            xval_reg     <= xval_next;
            argc_reg     <= argc_next;
            argv_reg     <= argv_next;
            dbase_reg    <= dbase_next;
            sbase_reg    <= sbase_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        func_reg    <= func_next;
        op_reg      <= op_next;
        opd_reg     <= opd_next;
        ldaddr_reg  <= ldaddr_next;
        lddata_reg  <= lddata_next;
        tmp_reg     <= tmp_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
